// File: rtl/assert_macros.svh
// Assertion macros for the checker file, tbi_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/tbi_pkg.sv
// Shared types for the triangle barycentric interpolator.
// No dependencies.
`default_nettype none

package tbi_pkg;

	typedef struct packed {
		logic valid;
		logic in_tri;
		logic degen;
		logic neg1;
		logic neg2;
	} tbi_ctl_t;

	typedef struct packed {
		logic saturated;
		logic degenerate;
		logic inside_res;
	} tbi_flags_t;

	localparam int unsigned IN_FIELDS = 11;
	localparam int unsigned CHUNK_BITS = 16;

endpackage

`default_nettype wire

// File: rtl/triangle_barycentric_interpolate.sv
// Top level: point-in-triangle test and barycentric elevation interpolation.
// Depends on tbi_pkg, tbi_front, tbi_div and tbi_interp.
//
//   channel | group              | tdata                              | tuser
//   input   | s_tvalid/s_tready  | v1_x v1_y v1_z v2_x v2_y v2_z      | -
//           |                    | v3_x v3_y v3_z point_x point_y     |
//   output  | m_tvalid/m_tready  | elevation                          | inside_res degenerate
//           |                    |                                    | saturated
//
// One request per cycle while s_tready is high; most of the pipeline depth is the
// one-bit-per-stage divider.
// arst_n clears all valid bits; payload registers are not reset.
// A stall on m_tready fills the output skid slot, then freezes the whole pipeline.
`default_nettype none

module triangle_barycentric_interpolate #(
	parameter int COORD_BITS       = 24,
	parameter int WEIGHT_FRAC_BITS = 16,
	localparam int IN_W  = ((tbi_pkg::IN_FIELDS * COORD_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((COORD_BITS + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, v3_x, v3_y, v3_z, point_x, point_y
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// elevation
	output logic [OUT_W-1:0] m_tdata,
	// inside_res, degenerate, saturated
	output logic [2:0]       m_tuser
);
	localparam int C = COORD_BITS;
	localparam int M = 2 * C + 1;
	localparam int Q = M + WEIGHT_FRAC_BITS;
	localparam int SW = 3 * C + 2;

	logic                en;
	tbi_pkg::tbi_ctl_t   f_ctl, d_ctl;
	logic [M-1:0]        f_det, f_n1, f_n2;
	logic [SW-1:0]       f_side, d_side;
	logic [Q-1:0]        d_q1, d_q2;
	logic                i_valid;
	tbi_pkg::tbi_flags_t i_flags, out_flags_q, skid_flags_q;
	logic [C-1:0]        i_elev, out_elev_q, skid_elev_q;
	logic                out_v_q, skid_v_q, pop;

	assign en       = !skid_v_q;
	assign s_tready = en;
	assign pop      = out_v_q && m_tready;

	tbi_front #(.COORD_BITS(C)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_valid(s_tvalid),
		.in_data (s_tdata[tbi_pkg::IN_FIELDS*C-1:0]),
		.ctl     (f_ctl),
		.det_mag (f_det),
		.n1_mag  (f_n1),
		.n2_mag  (f_n2),
		.side    (f_side)
	);

	tbi_div #(.MAG_BITS(M), .FRAC_BITS(WEIGHT_FRAC_BITS), .SIDE_BITS(SW)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_in  (f_ctl),
		.det_in  (f_det),
		.n1_in   (f_n1),
		.n2_in   (f_n2),
		.side_in (f_side),
		.ctl_out (d_ctl),
		.quo1    (d_q1),
		.quo2    (d_q2),
		.side_out(d_side)
	);

	tbi_interp #(.COORD_BITS(C), .FRAC_BITS(WEIGHT_FRAC_BITS), .QUO_BITS(Q)) u_interp (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.ctl_in   (d_ctl),
		.quo1     (d_q1),
		.quo2     (d_q2),
		.side_in  (d_side),
		.out_valid(i_valid),
		.out_flags(i_flags),
		.out_elev (i_elev)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (i_valid) begin
			if (out_v_q && !pop) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				out_flags_q <= skid_flags_q;
				out_elev_q  <= skid_elev_q;
			end
		end else if (i_valid) begin
			if (out_v_q && !pop) begin
				skid_flags_q <= i_flags;
				skid_elev_q  <= i_elev;
			end else begin
				out_flags_q <= i_flags;
				out_elev_q  <= i_elev;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = OUT_W'(out_elev_q);
	assign m_tuser  = out_flags_q;

endmodule

`default_nettype wire

// File: rtl/tbi_front.sv
// Edge differences, determinant, numerators, sign normalization and inside test.
// Depends on tbi_pkg.
`default_nettype none

module tbi_front #(
	parameter int COORD_BITS = 24
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       en,
	input  logic                                       in_valid,
	input  logic [tbi_pkg::IN_FIELDS*COORD_BITS-1:0]   in_data,
	output tbi_pkg::tbi_ctl_t                          ctl,
	output logic [2*COORD_BITS:0]                      det_mag,
	output logic [2*COORD_BITS:0]                      n1_mag,
	output logic [2*COORD_BITS:0]                      n2_mag,
	output logic [3*COORD_BITS+1:0]                    side
);
	localparam int C = COORD_BITS;
	localparam int D = C + 1;
	localparam int P = 2 * D;
	localparam int N = P + 1;
	localparam int M = 2 * C + 1;

	logic signed [C-1:0] f [tbi_pkg::IN_FIELDS];

	always_comb begin
		for (int k = 0; k < tbi_pkg::IN_FIELDS; k++) begin
			f[k] = in_data[k*C +: C];
		end
	end

	logic                v_s1, v_s2, v_s3, v_s4, v_s5;
	logic                in_tri_s5, degen_s5, neg1_s5, neg2_s5;
	logic signed [D-1:0] a11_s1, a12_s1, a21_s1, a22_s1, dx_s1, dy_s1;
	logic [3*C+1:0]      side_s1, side_s2, side_s3, side_s4;
	logic signed [P-1:0] p_s2 [6];
	logic signed [N-1:0] det_s3, n1_s3, n2_s3;
	logic signed [N-1:0] det_s4, n1_s4, n2_s4;
	logic                degen_s4;
	logic signed [N:0]   nsum;
	logic signed [N-1:0] n1_abs, n2_abs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	assign nsum   = (N+1)'(n1_s4) + (N+1)'(n2_s4);
	assign n1_abs = n1_s4[N-1] ? -n1_s4 : n1_s4;
	assign n2_abs = n2_s4[N-1] ? -n2_s4 : n2_s4;
	assign ctl    = '{valid: v_s5, in_tri: in_tri_s5, degen: degen_s5,
		neg1: neg1_s5, neg2: neg2_s5};

	always_ff @(posedge clk) begin
		if (en) begin
			a11_s1  <= D'(f[3]) - D'(f[0]);
			a12_s1  <= D'(f[6]) - D'(f[0]);
			a21_s1  <= D'(f[4]) - D'(f[1]);
			a22_s1  <= D'(f[7]) - D'(f[1]);
			dx_s1   <= D'(f[9]) - D'(f[0]);
			dy_s1   <= D'(f[10]) - D'(f[1]);
			side_s1 <= {D'(f[8]) - D'(f[2]), D'(f[5]) - D'(f[2]), f[2]};

			p_s2[0] <= a11_s1 * a22_s1;
			p_s2[1] <= a12_s1 * a21_s1;
			p_s2[2] <= a22_s1 * dx_s1;
			p_s2[3] <= a12_s1 * dy_s1;
			p_s2[4] <= a11_s1 * dy_s1;
			p_s2[5] <= a21_s1 * dx_s1;
			side_s2 <= side_s1;

			det_s3  <= N'(p_s2[0]) - N'(p_s2[1]);
			n1_s3   <= N'(p_s2[2]) - N'(p_s2[3]);
			n2_s3   <= N'(p_s2[4]) - N'(p_s2[5]);
			side_s3 <= side_s2;

			det_s4   <= det_s3[N-1] ? -det_s3 : det_s3;
			n1_s4    <= det_s3[N-1] ? -n1_s3 : n1_s3;
			n2_s4    <= det_s3[N-1] ? -n2_s3 : n2_s3;
			degen_s4 <= (det_s3 == '0);
			side_s4  <= side_s3;

			in_tri_s5 <= !degen_s4 && !n1_s4[N-1] && !n2_s4[N-1]
				&& (nsum <= (N+1)'(det_s4));
			degen_s5  <= degen_s4;
			neg1_s5   <= n1_s4[N-1];
			neg2_s5   <= n2_s4[N-1];
			det_mag   <= det_s4[M-1:0];
			n1_mag    <= n1_abs[M-1:0];
			n2_mag    <= n2_abs[M-1:0];
			side      <= side_s4;
		end
	end

endmodule

`default_nettype wire

// File: rtl/tbi_div.sv
// Two-lane pipelined restoring divider, one quotient bit per stage, shared divisor.
// Depends on tbi_pkg.
`default_nettype none

module tbi_div #(
	parameter int MAG_BITS  = 49,
	parameter int FRAC_BITS = 16,
	parameter int SIDE_BITS = 74
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  tbi_pkg::tbi_ctl_t             ctl_in,
	input  logic [MAG_BITS-1:0]           det_in,
	input  logic [MAG_BITS-1:0]           n1_in,
	input  logic [MAG_BITS-1:0]           n2_in,
	input  logic [SIDE_BITS-1:0]          side_in,
	output tbi_pkg::tbi_ctl_t             ctl_out,
	output logic [MAG_BITS+FRAC_BITS-1:0] quo1,
	output logic [MAG_BITS+FRAC_BITS-1:0] quo2,
	output logic [SIDE_BITS-1:0]          side_out
);
	localparam int M = MAG_BITS;
	localparam int Q = MAG_BITS + FRAC_BITS;

	tbi_pkg::tbi_ctl_t    ctl_s  [Q];
	logic [M-1:0]         det_s  [Q];
	logic [M-1:0]         r1_s   [Q];
	logic [M-1:0]         r2_s   [Q];
	logic [Q-1:0]         d1_s   [Q];
	logic [Q-1:0]         d2_s   [Q];
	logic [Q-1:0]         q1_s   [Q];
	logic [Q-1:0]         q2_s   [Q];
	logic [SIDE_BITS-1:0] side_s [Q];

	for (genvar i = 0; i < Q; i++) begin : g_stage
		tbi_pkg::tbi_ctl_t    ctl_src;
		logic [M-1:0]         det_src, r1_src, r2_src;
		logic [Q-1:0]         d1_src, d2_src, q1_src, q2_src;
		logic [SIDE_BITS-1:0] side_src;
		logic [M:0]           t1, t2;
		logic                 g1, g2;

		if (i == 0) begin : g_first
			assign ctl_src  = ctl_in;
			assign det_src  = det_in;
			assign r1_src   = '0;
			assign r2_src   = '0;
			assign d1_src   = {n1_in, {FRAC_BITS{1'b0}}};
			assign d2_src   = {n2_in, {FRAC_BITS{1'b0}}};
			assign q1_src   = '0;
			assign q2_src   = '0;
			assign side_src = side_in;
		end else begin : g_next
			assign ctl_src  = ctl_s[i-1];
			assign det_src  = det_s[i-1];
			assign r1_src   = r1_s[i-1];
			assign r2_src   = r2_s[i-1];
			assign d1_src   = d1_s[i-1];
			assign d2_src   = d2_s[i-1];
			assign q1_src   = q1_s[i-1];
			assign q2_src   = q2_s[i-1];
			assign side_src = side_s[i-1];
		end

		assign t1 = {r1_src, d1_src[Q-1]};
		assign t2 = {r2_src, d2_src[Q-1]};
		assign g1 = (t1 >= {1'b0, det_src});
		assign g2 = (t2 >= {1'b0, det_src});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[i] <= '0;
			end else if (en) begin
				ctl_s[i] <= ctl_src;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				det_s[i]  <= det_src;
				r1_s[i]   <= g1 ? M'(t1 - {1'b0, det_src}) : t1[M-1:0];
				r2_s[i]   <= g2 ? M'(t2 - {1'b0, det_src}) : t2[M-1:0];
				d1_s[i]   <= {d1_src[Q-2:0], 1'b0};
				d2_s[i]   <= {d2_src[Q-2:0], 1'b0};
				q1_s[i]   <= {q1_src[Q-2:0], g1};
				q2_s[i]   <= {q2_src[Q-2:0], g2};
				side_s[i] <= side_src;
			end
		end
	end

	assign ctl_out  = ctl_s[Q-1];
	assign quo1     = q1_s[Q-1];
	assign quo2     = q2_s[Q-1];
	assign side_out = side_s[Q-1];

endmodule

`default_nettype wire

// File: rtl/tbi_interp.sv
// Weighted elevation: chunked products, accumulate, round toward zero, saturate; v1_z passes through if degenerate.
// Depends on tbi_pkg.
`default_nettype none

module tbi_interp #(
	parameter int COORD_BITS = 24,
	parameter int FRAC_BITS  = 16,
	parameter int QUO_BITS   = 65
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  tbi_pkg::tbi_ctl_t       ctl_in,
	input  logic [QUO_BITS-1:0]     quo1,
	input  logic [QUO_BITS-1:0]     quo2,
	input  logic [3*COORD_BITS+1:0] side_in,
	output logic                    out_valid,
	output tbi_pkg::tbi_flags_t     out_flags,
	output logic [COORD_BITS-1:0]   out_elev
);
	localparam int C  = COORD_BITS;
	localparam int D  = C + 1;
	localparam int Q  = QUO_BITS;
	localparam int K  = tbi_pkg::CHUNK_BITS;
	localparam int NC = (Q + K - 1) / K;
	localparam int QP = NC * K;
	localparam int PPW = K + 1 + D;
	localparam int PW = Q + D + 1;
	localparam int AW = PW + 2;
	localparam int ZW = AW - FRAC_BITS;
	localparam logic [AW-1:0] RND = (AW'(1) << FRAC_BITS) - AW'(1);
	localparam logic [C-1:0] ZMAX = {1'b0, {(C-1){1'b1}}};
	localparam logic [C-1:0] ZMIN = {1'b1, {(C-1){1'b0}}};

	logic signed [C-1:0]   z1_in;
	logic signed [D-1:0]   dz2_in, dz3_in;
	logic [QP-1:0]         qp1, qp2;

	assign z1_in  = side_in[C-1:0];
	assign dz2_in = side_in[C+D-1:C];
	assign dz3_in = side_in[C+2*D-1:C+D];
	assign qp1    = QP'(quo1);
	assign qp2    = QP'(quo2);

	tbi_pkg::tbi_ctl_t     ctl_s1, ctl_s2, ctl_s3;
	logic signed [C-1:0]   z1_s1, z1_s2, z1_s3;
	logic signed [PPW-1:0] pp1_s1 [NC];
	logic signed [PPW-1:0] pp2_s1 [NC];
	logic signed [PW-1:0]  prod1_s2, prod2_s2;
	logic signed [PW-1:0]  sum1, sum2;
	logic signed [AW-1:0]  acc_s3;
	logic signed [AW-1:0]  accr;
	logic signed [ZW-1:0]  zq;
	logic                  in_range;

	always_comb begin
		sum1 = '0;
		sum2 = '0;
		for (int j = 0; j < NC; j++) begin
			sum1 = sum1 + (PW'(pp1_s1[j]) <<< (K*j));
			sum2 = sum2 + (PW'(pp2_s1[j]) <<< (K*j));
		end
	end

	assign accr     = acc_s3 + (acc_s3[AW-1] ? RND : '0);
	assign zq       = ZW'(accr >>> FRAC_BITS);
	assign in_range = (&zq[ZW-1:C-1]) | ~(|zq[ZW-1:C-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1    <= '0;
			ctl_s2    <= '0;
			ctl_s3    <= '0;
			out_valid <= 1'b0;
		end else if (en) begin
			ctl_s1    <= ctl_in;
			ctl_s2    <= ctl_s1;
			ctl_s3    <= ctl_s2;
			out_valid <= ctl_s3.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < NC; j++) begin
				pp1_s1[j] <= $signed({1'b0, qp1[j*K +: K]}) * dz2_in;
				pp2_s1[j] <= $signed({1'b0, qp2[j*K +: K]}) * dz3_in;
			end
			z1_s1 <= z1_in;

			prod1_s2 <= sum1;
			prod2_s2 <= sum2;
			z1_s2    <= z1_s1;

			acc_s3 <= (AW'(z1_s2) <<< FRAC_BITS)
				+ (ctl_s2.neg1 ? -AW'(prod1_s2) : AW'(prod1_s2))
				+ (ctl_s2.neg2 ? -AW'(prod2_s2) : AW'(prod2_s2));
			z1_s3  <= z1_s2;

			out_flags.inside_res <= ctl_s3.in_tri;
			out_flags.degenerate <= ctl_s3.degen;
			out_flags.saturated  <= !ctl_s3.degen && !in_range;
			if (ctl_s3.degen) begin
				out_elev <= z1_s3;
			end else if (in_range) begin
				out_elev <= zq[C-1:0];
			end else begin
				out_elev <= zq[ZW-1] ? ZMIN : ZMAX;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/tbi_checker.sv
// Port-level checks for the triangle barycentric interpolator, bound to the top level.
// Depends on assert_macros.svh and triangle_barycentric_interpolate.
`default_nettype none
`include "assert_macros.svh"

module tbi_checker #(
	parameter int COORD_BITS       = 24,
	parameter int WEIGHT_FRAC_BITS = 16,
	localparam int IN_W  = ((11 * COORD_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((COORD_BITS + 7) / 8) * 8
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic [IN_W-1:0]  s_tdata,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata,
	input logic [2:0]       m_tuser
);
	localparam logic [COORD_BITS-1:0] ZMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic [COORD_BITS-1:0] ZMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

	logic [COORD_BITS-1:0] elev;
	logic                  in_seen;

	assign elev    = m_tdata[COORD_BITS-1:0];
	assign in_seen = s_tvalid && s_tready;

	`ASSERT_IMPLIES(a_degen_flags, clk, arst_n, m_tvalid && m_tuser[1], !m_tuser[0] && !m_tuser[2])
	`ASSERT_IMPLIES(a_sat_limits, clk, arst_n, m_tvalid && m_tuser[2], elev == ZMAX || elev == ZMIN)
	`ASSERT_IMPLIES(a_stall_only_full, clk, arst_n, !s_tready || in_seen, m_tvalid || s_tready)
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind triangle_barycentric_interpolate tbi_checker #(
	.COORD_BITS      (COORD_BITS),
	.WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
) u_tbi_checker (.*);

`default_nettype wire
